// File: rtl/bop_pkg.sv
// Shared constants, status codes and the normal distribution tables of the option pricer.
package bop_pkg;

	localparam int TAB_DEPTH   = 1024;
	localparam int TAB_ENTRIES = TAB_DEPTH + 1;
	localparam int TAB_LOG2    = $clog2(TAB_DEPTH);
	localparam int IDX_W       = TAB_LOG2 + 1;

	localparam int SQRT_STEPS = 28;
	localparam int DIV_STEPS  = 27;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INTRINSIC = 2'd1;
	localparam logic [1:0] ST_SATURATED = 2'd2;

	localparam longint unsigned ONE_Q31          = 64'd1 << 31;
	localparam longint unsigned INV_SQRT_2PI_Q31 = 64'd856722024;
	localparam longint unsigned TAB_SQ           = longint'(TAB_DEPTH) * longint'(TAB_DEPTH);
	localparam longint unsigned SIMPSON_DEN      = 3 * longint'(TAB_DEPTH);

	typedef logic [31:0] tab_t [TAB_ENTRIES];

	function automatic longint unsigned mul31(longint unsigned a, longint unsigned b);
		return (a * b) >> 31;
	endfunction

	// PDF on the half-step grid x = 4*j/TAB_DEPTH, Q1.31
	function automatic longint unsigned half_step_pdf(longint unsigned j);
		longint unsigned num;
		longint unsigned y;
		longint unsigned z;
		longint unsigned e;
		num = 64'd8 * j * j;
		y = ((num / TAB_SQ) << 31) + (((num % TAB_SQ) << 31) / TAB_SQ);
		z = y >> 10;
		e = ONE_Q31;
		e = ONE_Q31 - mul31(z, e) / 5;
		e = ONE_Q31 - mul31(z, e) / 4;
		e = ONE_Q31 - mul31(z, e) / 3;
		e = ONE_Q31 - mul31(z, e) / 2;
		e = ONE_Q31 - mul31(z, e);
		for (int k = 0; k < 10; k++) begin
			e = mul31(e, e);
		end
		return mul31(e, INV_SQRT_2PI_Q31);
	endfunction

	function automatic tab_t build_pdf();
		tab_t t;
		for (int i = 0; i <= TAB_DEPTH; i++) begin
			t[i] = 32'(half_step_pdf(2 * longint'(i)));
		end
		return t;
	endfunction

	// Simpson integration of the PDF
	function automatic tab_t build_cdf();
		tab_t t;
		longint unsigned sum;
		longint unsigned c;
		longint unsigned j;
		sum = 0;
		t[0] = 32'(ONE_Q31 >> 1);
		for (int i = 0; i < TAB_DEPTH; i++) begin
			j = 2 * longint'(i);
			sum = sum + half_step_pdf(j) + 4 * half_step_pdf(j + 1) + half_step_pdf(j + 2);
			c = (ONE_Q31 >> 1) + (4 * sum) / SIMPSON_DEN;
			if (c > ONE_Q31) begin
				c = ONE_Q31;
			end
			t[i + 1] = 32'(c);
		end
		return t;
	endfunction

	localparam tab_t PDF_TAB = build_pdf();
	localparam tab_t CDF_TAB = build_cdf();

endpackage

// File: rtl/bop_in_if.sv
// Input channel of the option pricer: one option per item.
interface bop_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] forward_price;
	logic [31:0] strike_price;
	logic [31:0] expiry_years;
	logic [31:0] discount_factor;
	logic [31:0] abs_volatility;

	modport source(output valid, operation, forward_price, strike_price, expiry_years,
		discount_factor, abs_volatility, input ready);
	modport sink(input valid, operation, forward_price, strike_price, expiry_years,
		discount_factor, abs_volatility, output ready);
endinterface

// File: rtl/bop_out_if.sv
// Output channel of the option pricer: one price per item.
interface bop_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] option_price;
	logic [1:0]  status;

	modport source(output valid, option_price, status, input ready);
	modport sink(input valid, option_price, status, output ready);
endinterface

// File: rtl/bop_ram.sv
// Generic RAM: one write port, two registered read ports.
module bop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// File: rtl/bachelier_option_price.sv
// Top level of the pipelined Bachelier option pricer.
//
// Usage:
//   req carries one option per item (call/put selector, forward, strike,
//   expiry, discount factor, absolute volatility); rsp returns one item
//   per option: the discounted price (Q16.16, saturating) and a status
//   (ok, intrinsic value for zero vol-time, saturated).
//   Throughput is one item per cycle. The pipeline holds the 28 one-bit
//   stages of the square root and the 27 one-bit stages of the moneyness
//   division, plus the table read and the multiply stages around them.
//   After reset the CDF and PDF tables are copied into their RAMs, one
//   entry per cycle: req.ready stays low until all TAB_DEPTH+1 = 1025 are in.
//   When rsp stalls with a result waiting, the whole pipeline holds; items
//   keep flowing in as long as the output stage is empty or being taken.
//   Results leave in the order the items came in.
module bachelier_option_price
	import bop_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bop_in_if.sink      req,
	bop_out_if.source   rsp
);
	// stage map
	localparam int S_SV    = SQRT_STEPS + 1;
	localparam int S_DSET  = S_SV + 1;
	localparam int S_ADDR  = S_DSET + DIV_STEPS + 1;
	localparam int S_RD    = S_ADDR + 1;
	localparam int S_DIFF  = S_RD + 1;
	localparam int S_IMUL  = S_DIFF + 1;
	localparam int S_IADD  = S_IMUL + 1;
	localparam int S_TMUL  = S_IADD + 1;
	localparam int S_TSUM  = S_TMUL + 1;
	localparam int S_VAL   = S_TSUM + 1;
	localparam int S_DMUL  = S_VAL + 1;
	localparam int S_PRICE = S_DMUL + 1;
	localparam int S_OUT   = S_PRICE + 1;
	localparam int NST     = S_OUT + 1;
	localparam int POS_W   = 28 + TAB_LOG2 - 3;

	typedef struct packed {
		logic              mm_pos;
		logic [31:0]       um;
		logic [31:0]       df;
		logic [31:0]       sig;
		logic [55:0]       sq_v;
		logic [55:0]       sq_r;
		logic [59:0]       sv;
		logic              clamp;
		logic              zero;
		logic [63:0]       dv_r;
		logic [62:0]       dv_d;
		logic [26:0]       q;
		logic [IDX_W-1:0]  idx;
		logic [23:0]       f;
		logic [31:0]       ca;
		logic [31:0]       cd;
		logic              cs;
		logic [31:0]       pa;
		logic [31:0]       pd;
		logic              ps;
		logic [55:0]       cprod;
		logic [55:0]       pprod;
		logic [31:0]       c;
		logic [31:0]       p;
		logic [63:0]       t1m;
		logic [60:0]       t2h;
		logic [62:0]       t2l;
		logic [56:0]       t1;
		logic [60:0]       t2;
		logic [60:0]       val;
		logic [62:0]       ph;
		logic [61:0]       pl;
		logic [63:0]       price;
		logic [31:0]       res;
		logic [1:0]        status;
	} pipe_t;

	pipe_t            pipe_s [NST];
	pipe_t            nxt    [NST];
	logic [NST-1:0]   vld_s;
	logic             adv;

	logic [IDX_W-1:0] fill_q;
	logic             fill_done_q;
	logic [IDX_W-1:0] raddr_b;
	logic [31:0]      cdf_a, cdf_b, pdf_a, pdf_b;

	// one bit of the integer square root: test b = 4^(SQRT_STEPS-k)
	function automatic pipe_t sqrt_step(pipe_t s, int k);
		pipe_t       o;
		logic [55:0] b;
		logic [56:0] rb;
		o  = s;
		b  = 56'd1 << (2 * (SQRT_STEPS - k));
		rb = {1'b0, s.sq_r} + {1'b0, b};
		if ({1'b0, s.sq_v} >= rb) begin
			o.sq_v = s.sq_v - rb[55:0];
			o.sq_r = (s.sq_r >> 1) + b;
		end else begin
			o.sq_r = s.sq_r >> 1;
		end
		return o;
	endfunction

	// one quotient bit of a*2^24/sv, divisor scaled by 8
	function automatic pipe_t div_step(pipe_t s);
		pipe_t       o;
		logic [63:0] r2;
		o  = s;
		r2 = {s.dv_r[62:0], 1'b0};
		if (r2 >= {1'b0, s.dv_d}) begin
			o.dv_r = r2 - {1'b0, s.dv_d};
			o.q    = {s.q[25:0], 1'b1};
		end else begin
			o.dv_r = r2;
			o.q    = {s.q[25:0], 1'b0};
		end
		return o;
	endfunction

	always_comb begin
		logic [55:0]      a;
		logic [27:0]      mag;
		logic [POS_W-1:0] pos;
		logic [31:0]      nval;
		pipe_t            o;

		// capture: moneyness and option side
		o = '0;
		o.mm_pos = req.operation ? (req.strike_price >= req.forward_price)
			: (req.forward_price >= req.strike_price);
		o.um = (req.forward_price >= req.strike_price)
			? req.forward_price - req.strike_price
			: req.strike_price - req.forward_price;
		o.df   = req.discount_factor;
		o.sig  = req.abs_volatility;
		o.sq_v = {req.expiry_years, 24'd0};
		nxt[0] = o;

		for (int k = 1; k <= SQRT_STEPS; k++) begin
			nxt[k] = sqrt_step(pipe_s[k-1], k);
		end

		// sigma * sqrt(t)
		o = pipe_s[S_SV-1];
		o.sv = 60'(o.sig) * 60'(o.sq_r[27:0]);
		nxt[S_SV] = o;

		// clamp |d| at 8, seed the divider
		o = pipe_s[S_DSET-1];
		a = {o.um, 24'd0};
		o.clamp = {8'd0, a} >= {1'b0, o.sv, 3'b000};
		o.zero  = (o.sv == '0);
		o.dv_r  = o.clamp ? '0 : {8'd0, a};
		o.dv_d  = {o.sv, 3'b000};
		o.q     = '0;
		nxt[S_DSET] = o;

		for (int k = 1; k <= DIV_STEPS; k++) begin
			nxt[S_DSET+k] = div_step(pipe_s[S_DSET+k-1]);
		end

		// table position of |d|
		o = pipe_s[S_ADDR-1];
		mag = o.clamp ? 28'd1 << 27 : {1'b0, o.q};
		pos = POS_W'(mag) << (TAB_LOG2 - 3);
		o.idx = pos[POS_W-1:24];
		o.f   = pos[23:0];
		nxt[S_ADDR] = o;

		// table read in flight
		nxt[S_RD] = pipe_s[S_RD-1];

		// neighbor differences
		o = pipe_s[S_DIFF-1];
		o.ca = cdf_a;
		o.cs = cdf_b < cdf_a;
		o.cd = o.cs ? cdf_a - cdf_b : cdf_b - cdf_a;
		o.pa = pdf_a;
		o.ps = pdf_b < pdf_a;
		o.pd = o.ps ? pdf_a - pdf_b : pdf_b - pdf_a;
		nxt[S_DIFF] = o;

		o = pipe_s[S_IMUL-1];
		o.cprod = 56'(o.cd) * 56'(o.f);
		o.pprod = 56'(o.pd) * 56'(o.f);
		nxt[S_IMUL] = o;

		o = pipe_s[S_IADD-1];
		o.c = o.cs ? o.ca - o.cprod[55:24] : o.ca + o.cprod[55:24];
		o.p = o.ps ? o.pa - o.pprod[55:24] : o.pa + o.pprod[55:24];
		nxt[S_IADD] = o;

		// moneyness and volatility terms
		o = pipe_s[S_TMUL-1];
		nval  = o.mm_pos ? o.c : 32'(ONE_Q31) - o.c;
		o.t1m = 64'(o.um) * 64'(nval);
		o.t2h = 61'(o.sv[59:31]) * 61'(o.p);
		o.t2l = 63'(o.sv[30:0]) * 63'(o.p);
		nxt[S_TMUL] = o;

		o = pipe_s[S_TSUM-1];
		o.t1 = o.t1m[63:7];
		o.t2 = o.t2h + 61'(o.t2l[62:31]);
		nxt[S_TSUM] = o;

		o = pipe_s[S_VAL-1];
		if (o.zero) begin
			o.val = o.mm_pos ? 61'({o.um, 24'd0}) : '0;
		end else if (o.mm_pos) begin
			o.val = 61'(o.t1) + o.t2;
		end else begin
			o.val = (o.t2 > 61'(o.t1)) ? o.t2 - 61'(o.t1) : '0;
		end
		nxt[S_VAL] = o;

		// discount
		o = pipe_s[S_DMUL-1];
		o.ph = 63'(o.val[60:30]) * 63'(o.df);
		o.pl = 62'(o.val[29:0]) * 62'(o.df);
		nxt[S_DMUL] = o;

		o = pipe_s[S_PRICE-1];
		o.price = 64'(o.ph) + 64'(o.pl[61:30]);
		nxt[S_PRICE] = o;

		// round half up, saturate
		o = pipe_s[S_OUT-1];
		begin
			logic [63:0] rnd;
			rnd = o.price + (64'd1 << 23);
			if (|rnd[63:56]) begin
				o.res    = '1;
				o.status = ST_SATURATED;
			end else begin
				o.res    = rnd[55:24];
				o.status = o.zero ? ST_INTRINSIC : ST_OK;
			end
		end
		nxt[S_OUT] = o;
	end

	// hold everything while a finished result waits
	assign adv       = !vld_s[S_OUT] || rsp.ready;
	assign req.ready = adv && fill_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], req.valid && req.ready};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NST; k++) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	// table load after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			fill_done_q <= 1'b0;
		end else if (!fill_done_q) begin
			if (fill_q == IDX_W'(TAB_DEPTH)) begin
				fill_done_q <= 1'b1;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign raddr_b = (pipe_s[S_ADDR].idx == IDX_W'(TAB_DEPTH))
		? pipe_s[S_ADDR].idx : pipe_s[S_ADDR].idx + 1'b1;

	bop_ram #(.WIDTH(32), .DEPTH(TAB_ENTRIES)) u_cdf_ram (
		.clk     (clk),
		.we      (!fill_done_q),
		.waddr   (fill_q),
		.wdata   (CDF_TAB[fill_q]),
		.re      (adv),
		.raddr_a (pipe_s[S_ADDR].idx),
		.raddr_b (raddr_b),
		.rdata_a (cdf_a),
		.rdata_b (cdf_b)
	);

	bop_ram #(.WIDTH(32), .DEPTH(TAB_ENTRIES)) u_pdf_ram (
		.clk     (clk),
		.we      (!fill_done_q),
		.waddr   (fill_q),
		.wdata   (PDF_TAB[fill_q]),
		.re      (adv),
		.raddr_a (pipe_s[S_ADDR].idx),
		.raddr_b (raddr_b),
		.rdata_a (pdf_a),
		.rdata_b (pdf_b)
	);

	assign rsp.valid        = vld_s[S_OUT];
	assign rsp.option_price = pipe_s[S_OUT].res;
	assign rsp.status       = pipe_s[S_OUT].status;
endmodule

// File: rtl/bop_checker.sv
// Port-level checks of the option pricer output, bound to the top level.
module bop_checker
	import bop_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_option_price,
	input logic [1:0]  rsp_status
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_option_price) && $stable(rsp_status))
		else $error("result item changed under stall");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_INTRINSIC
			|| rsp_status == ST_SATURATED)
		else $error("undefined status code");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_SATURATED |-> rsp_option_price == 32'hFFFF_FFFF)
		else $error("saturated item without full-scale price");
endmodule

bind bachelier_option_price bop_checker u_bop_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_option_price (rsp.option_price),
	.rsp_status       (rsp.status)
);
